@@ rtl/sdrm_pkg.sv @@
package sdrm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 16;
    localparam int LIMIT_BITS  = 16;
    localparam int CLASS_BITS  = 2;

    localparam int PROD_BITS   = 2 * SAMPLE_BITS - 1;
    localparam int ENERGY_BITS = 2 * SAMPLE_BITS - 2 + COUNT_BITS;
    localparam int MEAN_BITS   = PROD_BITS;
    localparam int RAD_BITS    = 2 * SAMPLE_BITS;
    localparam int ALU_BITS    = (COUNT_BITS + 1 > SAMPLE_BITS + 2) ?
                                 COUNT_BITS + 1 : SAMPLE_BITS + 2;
    localparam int ITER_BITS   = $clog2(MEAN_BITS);

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 4;
    localparam int REG_SEL_BITS  = 2;

    localparam logic [REG_SEL_BITS-1:0] REG_WINDOW = 2'd0;
    localparam logic [REG_SEL_BITS-1:0] REG_QUIET  = 2'd1;
    localparam logic [REG_SEL_BITS-1:0] REG_LOUD   = 2'd2;

    localparam logic [COUNT_BITS-1:0] WINDOW_RESET = COUNT_BITS'(16000);
    localparam logic [LIMIT_BITS-1:0] QUIET_RESET  = LIMIT_BITS'(50);
    localparam logic [LIMIT_BITS-1:0] LOUD_RESET   = LIMIT_BITS'(500);

    typedef enum logic [CLASS_BITS-1:0] {
        CLS_SILENT  = 2'd0,
        CLS_QUIET   = 2'd1,
        CLS_AMBIENT = 2'd2,
        CLS_LOUD    = 2'd3
    } t_class;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_CHECK,
        S_DIV,
        S_SQRT,
        S_CLASS,
        S_DONE
    } t_state;

endpackage

@@ rtl/sdrm_if.sv @@
interface sdrm_in_if;
    import sdrm_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface sdrm_out_if;
    import sdrm_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] mono_sample;
    logic                          rms_valid;
    logic        [SAMPLE_BITS-1:0] rms_value;
    logic        [CLASS_BITS-1:0]  loudness_class;

    modport source (output valid, output mono_sample, output rms_valid,
                    output rms_value, output loudness_class, input ready);
    modport sink   (input valid, input mono_sample, input rms_valid,
                    input rms_value, input loudness_class, output ready);
endinterface

@@ rtl/stereo_downmix_rms_meter_unit.sv @@
// A frame that does not close a window passes S_MUL, S_ACC, S_CHECK and S_DONE;
// one that closes a window also runs a 31-step restoring divide and a 16-step square
// root (both on one shared subtractor) and S_CLASS before S_DONE.
// No new frame is taken until the last one has left S_DONE, which waits on output ready.
// Reset: synchronous active-low; clears accumulators, output valid, sequencer,
// and loads register defaults (window 16000, quiet 50, loud 500).
module stereo_downmix_rms_meter_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    sdrm_in_if.sink                              i_frame,
    sdrm_out_if.source                           o_result,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [sdrm_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [sdrm_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [sdrm_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready
);
    import sdrm_pkg::*;

    t_state                        r_state, n_state;
    logic [COUNT_BITS-1:0]         r_window;
    logic [LIMIT_BITS-1:0]         r_quiet, r_loud;

    logic signed [SAMPLE_BITS-1:0] r_mono, n_mono;
    logic [SAMPLE_BITS-1:0]        r_mag, n_mag;
    logic [PROD_BITS-1:0]          r_prod, n_prod;
    logic [ENERGY_BITS-1:0]        r_energy, n_energy;
    logic [COUNT_BITS-1:0]         r_count, n_count;
    logic [ALU_BITS-1:0]           r_rem, n_rem;
    logic [RAD_BITS-1:0]           r_work, n_work;
    logic [SAMPLE_BITS-1:0]        r_root, n_root;
    logic [ITER_BITS-1:0]          r_iter, n_iter;
    logic                          r_close, n_close;
    t_class                        r_class, n_class;

    logic                          r_out_valid, n_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_mono, n_out_mono;
    logic                          r_out_rms_valid, n_out_rms_valid;
    logic [SAMPLE_BITS-1:0]        r_out_rms, n_out_rms;
    t_class                        r_out_class, n_out_class;

    logic [ALU_BITS-1:0]           alu_a, alu_b, alu_diff;
    logic                          alu_borrow;
    logic                          alu_ge;
    logic [SAMPLE_BITS:0]          pair_sum;
    logic signed [SAMPLE_BITS-1:0] mono;
    logic                          cfg_wr;
    logic [REG_SEL_BITS-1:0]       reg_sel;

    // config port
    assign pready  = 1'b1;
    assign reg_sel = paddr[REG_SEL_BITS+1:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_comb begin
        case (reg_sel)
            REG_WINDOW: prdata = APB_DATA_BITS'(r_window);
            REG_QUIET:  prdata = APB_DATA_BITS'(r_quiet);
            REG_LOUD:   prdata = APB_DATA_BITS'(r_loud);
            default:    prdata = '0;
        endcase
    end

    // downmix
    assign pair_sum = {i_frame.left_sample[SAMPLE_BITS-1], i_frame.left_sample}
                    + {i_frame.right_sample[SAMPLE_BITS-1], i_frame.right_sample};
    assign mono     = pair_sum[SAMPLE_BITS:1];

    // shared subtractor: divide and square root steps
    always_comb begin
        case (r_state)
            S_DIV: begin
                alu_a = {r_rem[ALU_BITS-2:0], r_work[MEAN_BITS-1]};
                alu_b = ALU_BITS'(r_count);
            end
            S_SQRT: begin
                alu_a = {r_rem[ALU_BITS-3:0], r_work[RAD_BITS-1:RAD_BITS-2]};
                alu_b = ALU_BITS'({r_root, 2'b01});
            end
            default: begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    assign {alu_borrow, alu_diff} = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_ge = ~alu_borrow;

    assign i_frame.ready           = (r_state == S_IDLE);
    assign o_result.valid          = r_out_valid;
    assign o_result.mono_sample    = r_out_mono;
    assign o_result.rms_valid      = r_out_rms_valid;
    assign o_result.rms_value      = r_out_rms;
    assign o_result.loudness_class = r_out_class;

    always_comb begin
        n_state         = r_state;
        n_mono          = r_mono;
        n_mag           = r_mag;
        n_prod          = r_prod;
        n_energy        = r_energy;
        n_count         = r_count;
        n_rem           = r_rem;
        n_work          = r_work;
        n_root          = r_root;
        n_iter          = r_iter;
        n_close         = r_close;
        n_class         = r_class;
        n_out_valid     = r_out_valid & ~o_result.ready;
        n_out_mono      = r_out_mono;
        n_out_rms_valid = r_out_rms_valid;
        n_out_rms       = r_out_rms;
        n_out_class     = r_out_class;

        case (r_state)
            S_IDLE: begin
                if (i_frame.valid) begin
                    n_mono  = mono;
                    n_mag   = mono[SAMPLE_BITS-1] ? SAMPLE_BITS'(~mono + 1'b1) : mono;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = PROD_BITS'(r_mag) * PROD_BITS'(r_mag);
                n_state = S_ACC;
            end
            S_ACC: begin
                n_energy = r_energy + ENERGY_BITS'(r_prod);
                n_count  = r_count + 1'b1;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                if (r_count >= r_window) begin
                    n_close = 1'b1;
                    if (r_count == '0) begin
                        n_root  = '0;
                        n_state = S_CLASS;
                    end else begin
                        n_rem   = ALU_BITS'(r_energy[ENERGY_BITS-1:MEAN_BITS]);
                        n_work  = RAD_BITS'(r_energy[MEAN_BITS-1:0]);
                        n_iter  = ITER_BITS'(MEAN_BITS - 1);
                        n_state = S_DIV;
                    end
                end else begin
                    n_close = 1'b0;
                    n_root  = '0;
                    n_class = CLS_SILENT;
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                n_rem  = alu_ge ? alu_diff : alu_a;
                n_work = RAD_BITS'({r_work[MEAN_BITS-2:0], alu_ge});
                n_iter = r_iter - 1'b1;
                if (r_iter == '0) begin
                    n_rem   = '0;
                    n_root  = '0;
                    n_iter  = ITER_BITS'(SAMPLE_BITS - 1);
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                n_rem  = alu_ge ? alu_diff : alu_a;
                n_work = {r_work[RAD_BITS-3:0], 2'b00};
                n_root = {r_root[SAMPLE_BITS-2:0], alu_ge};
                n_iter = r_iter - 1'b1;
                if (r_iter == '0) begin
                    n_state = S_CLASS;
                end
            end
            S_CLASS: begin
                if (r_root == '0) begin
                    n_class = CLS_SILENT;
                end else if (r_root < r_quiet) begin
                    n_class = CLS_QUIET;
                end else if (r_root < r_loud) begin
                    n_class = CLS_AMBIENT;
                end else begin
                    n_class = CLS_LOUD;
                end
                n_energy = '0;
                n_count  = '0;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (~r_out_valid | o_result.ready) begin
                    n_out_valid     = 1'b1;
                    n_out_mono      = r_mono;
                    n_out_rms_valid = r_close;
                    n_out_rms       = r_root;
                    n_out_class     = r_class;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_energy    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_window    <= WINDOW_RESET;
            r_quiet     <= QUIET_RESET;
            r_loud      <= LOUD_RESET;
        end else begin
            r_state     <= n_state;
            r_energy    <= n_energy;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                case (reg_sel)
                    REG_WINDOW: r_window <= pwdata[COUNT_BITS-1:0];
                    REG_QUIET:  r_quiet  <= pwdata[LIMIT_BITS-1:0];
                    REG_LOUD:   r_loud   <= pwdata[LIMIT_BITS-1:0];
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mono          <= n_mono;
        r_mag           <= n_mag;
        r_prod          <= n_prod;
        r_rem           <= n_rem;
        r_work          <= n_work;
        r_root          <= n_root;
        r_iter          <= n_iter;
        r_close         <= n_close;
        r_class         <= n_class;
        r_out_mono      <= n_out_mono;
        r_out_rms_valid <= n_out_rms_valid;
        r_out_rms       <= n_out_rms;
        r_out_class     <= n_out_class;
    end

endmodule
